>>> src/qse_pkg.sv
// Shared types and constants of the quoted string escaper.
// Holds the escape plan of one byte and the helpers that spell it out.
// Depends on nothing.
`default_nettype none

package qse_pkg;

	localparam logic [7:0] QUOTE_CHAR     = 8'h27;
	localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
	localparam logic [7:0] DELETE_CHAR    = 8'h7F;
	localparam logic [7:0] CONTROL_LIMIT  = 8'h20;
	localparam logic [7:0] CHAR_U         = 8'h75;
	localparam logic [7:0] CHAR_ZERO      = 8'h30;
	localparam logic [7:0] CHAR_A_LOWER   = 8'h61;

	// Depth of the plan queue between front and back.
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCOUNT_W = $clog2(QDEPTH + 1);

	// How one input word is to be written out.
	typedef enum logic [1:0] {
		KIND_PASS  = 2'd0,
		KIND_SHORT = 2'd1,
		KIND_UNI   = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	// Classified word: for KIND_SHORT data holds the escape letter,
	// otherwise the original byte.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       start;
		logic       stop;
	} plan_t;

	// Lower-case hex digit of a nibble.
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CHAR_ZERO + {4'd0, nib};
		end else begin
			r = CHAR_A_LOWER + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

	// Number of body bytes the plan produces (not counting quotes).
	function automatic logic [2:0] body_len(input kind_t kind);
		logic [2:0] r;
		unique case (kind)
			KIND_PASS:  r = 3'd1;
			KIND_SHORT: r = 3'd2;
			KIND_UNI:   r = 3'd6;
			KIND_EMPTY: r = 3'd0;
		endcase
		return r;
	endfunction

	// Body byte at a given position of the escape.
	function automatic logic [7:0] body_byte(input plan_t p, input logic [2:0] pos);
		logic [7:0] r;
		r = p.data;
		if (p.kind == KIND_SHORT) begin
			r = (pos == 3'd0) ? BACKSLASH_CHAR : p.data;
		end else if (p.kind == KIND_UNI) begin
			unique case (pos)
				3'd0:    r = BACKSLASH_CHAR;
				3'd1:    r = CHAR_U;
				3'd2:    r = CHAR_ZERO;
				3'd3:    r = CHAR_ZERO;
				3'd4:    r = hex_digit(p.data[7:4]);
				default: r = hex_digit(p.data[3:0]);
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/qse_front.sv
// Front end of the quoted string escaper: accepts input words and classifies them.
// Registers one escape plan and hands it to the plan queue. Depends on qse_pkg.
`default_nettype none

module qse_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          text_start,
	input  wire logic          text_end,
	input  wire logic          empty_text,
	output logic               push,
	output qse_pkg::plan_t     push_plan,
	input  wire logic          q_full
);
	import qse_pkg::*;

	logic  valid_s1;
	plan_t plan_s1;
	plan_t plan_new;

	// Pick the escape form of the incoming byte.
	always_comb begin
		plan_new.start = text_start;
		plan_new.stop  = text_end;
		plan_new.data  = in_byte;
		plan_new.kind  = KIND_PASS;
		priority if (empty_text) begin
			plan_new.kind = KIND_EMPTY;
		end else if (in_byte == 8'h08) begin
			plan_new.kind = KIND_SHORT;
			plan_new.data = 8'h62;
		end else if (in_byte == 8'h0C) begin
			plan_new.kind = KIND_SHORT;
			plan_new.data = 8'h66;
		end else if (in_byte == 8'h0A) begin
			plan_new.kind = KIND_SHORT;
			plan_new.data = 8'h6E;
		end else if (in_byte == 8'h0D) begin
			plan_new.kind = KIND_SHORT;
			plan_new.data = 8'h72;
		end else if (in_byte == 8'h09) begin
			plan_new.kind = KIND_SHORT;
			plan_new.data = 8'h74;
		end else if (in_byte == 8'h0B) begin
			plan_new.kind = KIND_SHORT;
			plan_new.data = 8'h76;
		end else if (in_byte == BACKSLASH_CHAR || in_byte == QUOTE_CHAR) begin
			plan_new.kind = KIND_SHORT;
		end else if (in_byte < CONTROL_LIMIT || in_byte == DELETE_CHAR) begin
			plan_new.kind = KIND_UNI;
		end else begin
			plan_new.kind = KIND_PASS;
		end
	end

	// The stage moves on when it is empty or its plan enters the queue.
	assign in_ready  = !valid_s1 || !q_full;
	assign push      = valid_s1 && !q_full;
	assign push_plan = plan_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			plan_s1 <= plan_new;
		end
	end

endmodule

`default_nettype wire

>>> src/qse_queue.sv
// Short queue of escape plans between the front and the back end.
// Lets either side stall on its own. Depends on qse_pkg.
`default_nettype none

module qse_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  qse_pkg::plan_t      push_plan,
	output logic                full,
	input  wire logic           pop,
	output logic                q_valid,
	output qse_pkg::plan_t      q_plan
);
	import qse_pkg::*;

	plan_t                mem_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QCOUNT_W-1:0]  count_q;

	assign full    = (count_q == QCOUNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_plan  = mem_q[rd_ptr_q];

	// Pointer and fill bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage of the plans themselves.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_plan;
		end
	end

endmodule

`default_nettype wire

>>> src/qse_back.sv
// Back end of the quoted string escaper: spells each plan out byte by byte.
// Drives the registered output words. Depends on qse_pkg.
`default_nettype none

module qse_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  qse_pkg::plan_t   q_plan,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             literal_end
);
	import qse_pkg::*;

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       lit_q;

	logic       load;
	logic [2:0] pos;
	logic [2:0] len;
	logic [3:0] total;
	logic [7:0] cur_byte;
	logic       cur_last;
	logic       cur_lit;

	assign load = q_valid && (!valid_q || out_ready);
	assign pop  = load && cur_last;

	// Byte at the current position: opening quote, body, closing quote.
	always_comb begin
		len   = body_len(q_plan.kind);
		pos   = idx_q - {2'd0, q_plan.start};
		total = {1'b0, len} + {3'd0, q_plan.start} + {3'd0, q_plan.stop};
		if (q_plan.kind == KIND_EMPTY) begin
			cur_byte = QUOTE_CHAR;
			cur_last = (idx_q == 3'd1);
			cur_lit  = cur_last;
		end else begin
			cur_last = ({1'b0, idx_q} == total - 4'd1);
			cur_lit  = 1'b0;
			if (q_plan.start && idx_q == 3'd0) begin
				cur_byte = QUOTE_CHAR;
			end else if (pos < len) begin
				cur_byte = body_byte(q_plan, pos);
			end else begin
				cur_byte = QUOTE_CHAR;
				cur_lit  = 1'b1;
			end
		end
	end

	// Position counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= cur_last ? 3'd0 : idx_q + 3'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			last_q <= cur_last;
			lit_q  <= cur_lit;
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign run_last    = last_q;
	assign literal_end = lit_q;

endmodule

`default_nettype wire

>>> src/quoted_string_escaper_unit.sv
// Top level of the quoted string escaper: front end, plan queue and back end.
// Depends on qse_pkg, qse_front, qse_queue and qse_back.
//
// Turns a stream of UTF-8 bytes, one per input word, into a single-quoted
// literal. An opening apostrophe precedes a word marked as start of text, a
// closing apostrophe follows one marked as end (tlast). Control escapes
// (\b \f \n \r \t \v \\ \') take two bytes, other bytes below 0x20 and 0x7F
// take six (\u00xx, lower-case hex), everything else passes as is; an empty
// text word yields two apostrophes. One input word is taken per cycle while
// the queue has room, and the output emits one byte per cycle while it is
// ready, so a word produces one to eight output bytes; the byte counter of
// the back end steps through them, and a four-entry queue absorbs the
// difference. With the queue empty and the output register free, a word
// passes the front stage register, the queue and the output register in turn.
`default_nettype none

module quoted_string_escaper_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  wire logic       s_axis_tlast,  // text_end
	input  wire logic [1:0] s_axis_tuser,  // [0] text_start, [1] empty_text
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
	output logic            m_axis_tlast,  // literal_end
	output logic            m_axis_tuser   // [0] run_last
);
	import qse_pkg::*;

	logic  push;
	plan_t push_plan;
	logic  q_full;
	logic  pop;
	logic  q_valid;
	plan_t q_plan;

	// Classify incoming words.
	qse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.text_start (s_axis_tuser[0]),
		.text_end   (s_axis_tlast),
		.empty_text (s_axis_tuser[1]),
		.push       (push),
		.push_plan  (push_plan),
		.q_full     (q_full)
	);

	// Buffer plans between the two ends.
	qse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_plan (push_plan),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_plan    (q_plan)
	);

	// Emit the escaped bytes.
	qse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_plan      (q_plan),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.run_last    (m_axis_tuser),
		.literal_end (m_axis_tlast)
	);

endmodule

`default_nettype wire
